@@ design/heap_sweep_coalescer_defines.svh @@
// ----------------------------------------------------------------------------
// heap sweep coalescer assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef HEAP_SWEEP_COALESCER_DEFINES_SVH
`define HEAP_SWEEP_COALESCER_DEFINES_SVH

// same-cycle implication
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// shared types, constants and helpers of the heap sweep coalescer
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_NUM_CLASSES = 8;
    localparam int WORD_W          = 32;
    localparam int CLASS_W         = 3;

    typedef enum logic [1:0] {
        ACT_KEEP  = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_NEW   = 2'd2
    } action_t;

    // free run closed by this word
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] words;
    } close_t;

    // list push result
    typedef struct packed {
        logic               link_valid;
        logic [CLASS_W-1:0] block_class;
        logic               was_empty;
    } push_t;

    typedef struct packed {
        logic [WORD_W-1:0] freed_objects;
        logic [WORD_W-1:0] freed_words;
        logic [WORD_W-1:0] kept_objects;
        logic [WORD_W-1:0] kept_words;
    } counts_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W:0] class_min(input int unsigned i);
        logic [WORD_W:0] m;
        if (i == 0) begin
            m = (WORD_W+1)'(2);
        end else if (i == 1) begin
            m = (WORD_W+1)'(3);
        end else begin
            m = (WORD_W+1)'(1) << i;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ design/heap_sweep_coalescer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// heap_sweep_coalescer
// Sweep stage of a mark-sweep heap. Object headers come in one word per
// cycle in address order; marked objects are kept, unmarked and free ones
// merge into a run, and each closed run of two or more words is pushed onto
// one of the size class free lists with the old head as its next link. The
// block takes one word every cycle unless a held result stalls it; each
// word goes into the input register, then its result into the result
// register, with run merge, class select and list head update done between them.
// ----------------------------------------------------------------------------
`include "heap_sweep_coalescer_defines.svh"

module heap_sweep_coalescer
    import hsc_pkg::*;
#(
    parameter int ADDR_BITS   = DEF_ADDR_BITS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_start_of_sweep,
    input  wire logic [WORD_W-1:0]   s_obj_addr,
    input  wire logic [WORD_W-1:0]   s_obj_size,
    input  wire logic                s_is_free,
    input  wire logic                s_is_marked,
    input  wire logic                s_last_in_arena,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_obj_action,
    output logic                     m_link_valid,
    output logic [WORD_W-1:0]        m_block_addr,
    output logic [WORD_W-1:0]        m_block_size,
    output logic [CLASS_W-1:0]       m_block_class,
    output logic [WORD_W-1:0]        m_block_next,
    output logic                     m_list_was_empty,
    output logic [WORD_W-1:0]        m_freed_objects,
    output logic [WORD_W-1:0]        m_freed_words,
    output logic [WORD_W-1:0]        m_kept_objects,
    output logic [WORD_W-1:0]        m_kept_words
);

    // input register
    logic              in_valid_reg;
    logic              in_start_reg;
    logic [WORD_W-1:0] in_addr_reg;
    logic [WORD_W-1:0] in_size_reg;
    logic              in_free_reg;
    logic              in_marked_reg;
    logic              in_last_reg;

    // result register
    logic              m_valid_reg;
    logic [1:0]        m_action_reg;
    logic              m_link_reg;
    logic [WORD_W-1:0] m_baddr_reg;
    logic [WORD_W-1:0] m_bsize_reg;
    logic [CLASS_W-1:0] m_bclass_reg;
    logic [WORD_W-1:0] m_bnext_reg;
    logic              m_empty_reg;
    counts_t           m_counts_reg;

    logic                 adv;
    logic                 s_take;
    logic [ADDR_BITS+WORD_W-1:0] addr_wide;
    logic [ADDR_BITS-1:0] addr_m;
    action_t              action;
    close_t               close;
    logic [ADDR_BITS-1:0] close_addr;
    counts_t              counts;
    push_t                push;
    logic [ADDR_BITS-1:0] next_addr;
    logic [ADDR_BITS+WORD_W-1:0] close_addr_wide;
    logic [ADDR_BITS+WORD_W-1:0] next_addr_wide;

    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign s_take  = s_valid && s_ready;

    assign addr_wide       = {{ADDR_BITS{1'b0}}, in_addr_reg};
    assign addr_m          = addr_wide[ADDR_BITS-1:0];
    assign close_addr_wide = {{WORD_W{1'b0}}, close_addr};
    assign next_addr_wide  = {{WORD_W{1'b0}}, next_addr};

    hsc_run #(
        .ADDR_BITS (ADDR_BITS)
    ) u_run (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .start      (in_start_reg),
        .addr       (addr_m),
        .size       (in_size_reg),
        .is_free    (in_free_reg),
        .is_marked  (in_marked_reg),
        .last       (in_last_reg),
        .action     (action),
        .close      (close),
        .close_addr (close_addr),
        .counts     (counts)
    );

    hsc_lists #(
        .ADDR_BITS   (ADDR_BITS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_lists (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .start      (in_start_reg),
        .close      (close),
        .close_addr (close_addr),
        .push       (push),
        .next_addr  (next_addr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_start_reg  <= s_start_of_sweep;
            in_addr_reg   <= s_obj_addr;
            in_size_reg   <= s_obj_size;
            in_free_reg   <= s_is_free;
            in_marked_reg <= s_is_marked;
            in_last_reg   <= s_last_in_arena;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_action_reg <= action;
            m_link_reg   <= push.link_valid;
            m_baddr_reg  <= close.valid ? close_addr_wide[WORD_W-1:0] : '0;
            m_bsize_reg  <= close.valid ? close.words : '0;
            m_bclass_reg <= push.block_class;
            m_bnext_reg  <= next_addr_wide[WORD_W-1:0];
            m_empty_reg  <= push.was_empty;
            m_counts_reg <= counts;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_obj_action     = m_action_reg;
    assign m_link_valid     = m_link_reg;
    assign m_block_addr     = m_baddr_reg;
    assign m_block_size     = m_bsize_reg;
    assign m_block_class    = m_bclass_reg;
    assign m_block_next     = m_bnext_reg;
    assign m_list_was_empty = m_empty_reg;
    assign m_freed_objects  = m_counts_reg.freed_objects;
    assign m_freed_words    = m_counts_reg.freed_words;
    assign m_kept_objects   = m_counts_reg.kept_objects;
    assign m_kept_words     = m_counts_reg.kept_words;

    `HSC_ASSERT_NOW(a_ready_when_out_free, !m_valid_reg, s_ready,
        "input stalled with empty result register")
    `HSC_ASSERT_NEXT(a_adv_fills_result, adv, m_valid_reg,
        "advanced word produced no result")
    `HSC_ASSERT_NOW(a_push_min_size, m_valid_reg && m_link_reg, m_bsize_reg >= WORD_W'(2),
        "linked block shorter than two words")
    `HSC_ASSERT_NOW(a_empty_null_next, m_valid_reg && m_empty_reg,
        m_link_reg && m_bnext_reg == '0, "empty list push with non-null next")

endmodule
`default_nettype wire

@@ design/hsc_run.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_run
// pending free run tracking and freed / kept counters
// ----------------------------------------------------------------------------
module hsc_run
    import hsc_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 start,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [WORD_W-1:0]    size,
    input  wire logic                 is_free,
    input  wire logic                 is_marked,
    input  wire logic                 last,
    output action_t                   action,
    output close_t                    close,
    output logic [ADDR_BITS-1:0]      close_addr,
    output counts_t                   counts
);

    logic                 run_open_reg, run_open_next;
    logic [ADDR_BITS-1:0] run_start_reg, run_start_next;
    logic [WORD_W-1:0]    run_words_reg, run_words_next;
    counts_t              counts_reg;

    logic                 ro;
    logic [ADDR_BITS-1:0] rs;
    logic [WORD_W-1:0]    rw;
    counts_t              cur;
    logic                 add;
    logic [WORD_W-1:0]    w;
    logic [ADDR_BITS-1:0] sa;

    always_comb begin
        ro  = start ? 1'b0 : run_open_reg;
        rs  = start ? '0 : run_start_reg;
        rw  = start ? '0 : run_words_reg;
        cur = start ? '0 : counts_reg;
        add = is_free || !is_marked;

        if (ro) begin
            w  = sat_add(rw, size);
            sa = rs;
        end else begin
            w  = size;
            sa = addr;
        end

        if (!add) begin
            action = ACT_KEEP;
        end else if (ro) begin
            action = ACT_MERGE;
        end else begin
            action = ACT_NEW;
        end

        // marked object closes the old run, end of arena closes the run holding this word
        if (add) begin
            close.valid = last && (w >= WORD_W'(2));
            close.words = w;
            close_addr  = sa;
        end else begin
            close.valid = ro && (rw >= WORD_W'(2));
            close.words = rw;
            close_addr  = rs;
        end

        if (add && !last) begin
            run_open_next  = 1'b1;
            run_start_next = sa;
            run_words_next = w;
        end else begin
            run_open_next  = 1'b0;
            run_start_next = '0;
            run_words_next = '0;
        end

        counts = cur;
        if (!is_free && !is_marked) begin
            counts.freed_objects = sat_add(cur.freed_objects, WORD_W'(1));
            counts.freed_words   = sat_add(cur.freed_words, size);
        end
        if (!is_free && is_marked) begin
            counts.kept_objects = sat_add(cur.kept_objects, WORD_W'(1));
            counts.kept_words   = sat_add(cur.kept_words, size);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            run_words_reg <= '0;
            counts_reg    <= '0;
        end else if (adv) begin
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            run_words_reg <= run_words_next;
            counts_reg    <= counts;
        end
    end

endmodule
`default_nettype wire

@@ design/hsc_lists.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_lists
// size class select and free list head registers
// ----------------------------------------------------------------------------
module hsc_lists
    import hsc_pkg::*;
#(
    parameter int ADDR_BITS   = DEF_ADDR_BITS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 start,
    input  wire close_t               close,
    input  wire logic [ADDR_BITS-1:0] close_addr,
    output push_t                     push,
    output logic [ADDR_BITS-1:0]      next_addr
);

    localparam int CW = $clog2(NUM_CLASSES);

    logic [NUM_CLASSES-1:0] head_valid_reg, head_valid_next;
    logic [ADDR_BITS-1:0]   head_addr_reg [NUM_CLASSES];

    logic [CW-1:0]   cls;
    logic [CW+2:0]   cls_wide;
    logic            hv;

    always_comb begin
        cls = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if ({1'b0, close.words} >= class_min(i)) begin
                cls = CW'(i);
            end
        end
        cls_wide = {3'b000, cls};

        hv = !start && head_valid_reg[cls];

        push.link_valid  = close.valid;
        push.block_class = close.valid ? cls_wide[CLASS_W-1:0] : '0;
        push.was_empty   = close.valid && !hv;
        next_addr        = (close.valid && hv) ? head_addr_reg[cls] : '0;

        head_valid_next = start ? '0 : head_valid_reg;
        if (close.valid) begin
            head_valid_next[cls] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
        end else if (adv) begin
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && close.valid) begin
            head_addr_reg[cls] <= close_addr;
        end
    end

endmodule
`default_nettype wire
